### rtl/core/rthov_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthov_pkg: shared types and constants of the rectangle table
// Sizes, the rectangle record, the per-cell control bundle and the codes
// of operations, result kinds and controller states.
// ----------------------------------------------------------------------------
package rthov_pkg;

	localparam int unsigned DEPTH         = 64;
	localparam int unsigned COORD_WIDTH   = 16;
	localparam int unsigned MAX_RESULTS   = 64;
	localparam int unsigned OPC_W         = 2;
	localparam int unsigned KIND_W        = 2;
	localparam int unsigned INDEX_FIELD_W = 6;
	localparam int unsigned IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W         = $clog2(DEPTH + 1);
	localparam int unsigned KEPT_W        = $clog2(MAX_RESULTS + 1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t l;
		coord_t t;
		coord_t r;
		coord_t b;
	} rect_t;

	// Control bundle broadcast from the controller to every cell.
	typedef struct packed {
		logic load;         // load probe, clear flag
		logic point_mode;   // probe takes the query point instead of the home entry
		logic shift_probe;  // probe ring moves one cell
		logic cmp_en;       // fold the overlap test into the flag
		logic rotate_home;  // home entries and flags move one cell toward cell 0
	} cell_ctrl_t;

	typedef enum logic [OPC_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_HIT    = 2'd2,
		OP_FILTER = 2'd3
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACK  = 2'd0,
		KIND_HIT  = 2'd1,
		KIND_KEPT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		kind_t                    kind;
		logic                     status;
		logic                     found;
		logic [INDEX_FIELD_W-1:0] idx;
		rect_t                    rect;
		logic                     last;
	} result_t;

	// Low bits of a table index as carried by the result's index field.
	function automatic logic [INDEX_FIELD_W-1:0] idx_to_field(input logic [IDX_W-1:0] v);
		logic [IDX_W+INDEX_FIELD_W-1:0] wide;
		wide = {{INDEX_FIELD_W{1'b0}}, v};
		return wide[INDEX_FIELD_W-1:0];
	endfunction

endpackage

### rtl/core/rthov_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rthov_cell: one table entry of the rectangle chain
// Holds a home rectangle and a traveling probe; tests the two for overlap
// (a point probe is a degenerate rectangle) and hands both to its neighbor.
// ----------------------------------------------------------------------------
module rthov_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rthov_pkg::cell_ctrl_t ctrl,
	input  logic                  we,
	input  rthov_pkg::rect_t      wr_rect,
	input  rthov_pkg::rect_t      point_rect,
	input  logic                  home_valid,
	input  rthov_pkg::rect_t      nbr_home,
	input  logic                  nbr_flag,
	input  rthov_pkg::rect_t      nbr_probe,
	input  logic                  nbr_probe_valid,
	output rthov_pkg::rect_t      home,
	output logic                  flag,
	output rthov_pkg::rect_t      probe,
	output logic                  probe_valid
);

	rthov_pkg::rect_t home_q;
	rthov_pkg::rect_t probe_q;
	logic             flag_q;
	logic             probe_valid_q;
	logic             overlap;

	// Inclusive bounds: touching edges count as overlap.
	assign overlap = !((home_q.l > probe_q.r) || (home_q.r < probe_q.l) ||
	                   (home_q.t > probe_q.b) || (home_q.b < probe_q.t));

	always_ff @(posedge clk) begin
		if (we) begin
			home_q <= wr_rect;
		end else if (ctrl.rotate_home) begin
			home_q <= nbr_home;
		end
		if (ctrl.load) begin
			probe_q <= ctrl.point_mode ? point_rect : home_q;
		end else if (ctrl.shift_probe) begin
			probe_q <= nbr_probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q        <= 1'b0;
			probe_valid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				flag_q        <= 1'b0;
				probe_valid_q <= ctrl.point_mode | home_valid;
			end else begin
				if (ctrl.cmp_en) begin
					flag_q <= flag_q | (home_valid & probe_valid_q & overlap);
				end else if (ctrl.rotate_home) begin
					flag_q <= nbr_flag;
				end
				if (ctrl.shift_probe) begin
					probe_valid_q <= nbr_probe_valid;
				end
			end
		end
	end

	assign home        = home_q;
	assign flag        = flag_q;
	assign probe       = probe_q;
	assign probe_valid = probe_valid_q;

endmodule

### rtl/core/rectangle_table_hit_and_overlap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_table_hit_and_overlap: rectangle table with hit-test and filter
// Timing: clear and append answer in the cycle after acceptance and are taken
//   back to back. A hit-test answers after passing through the compare, scan
//   and finish states, as does a filter with its last result; busy stays high
//   until then. The ring of cells moves one hop per cycle.
// Reset: asynchronous, active low; the table comes up empty, results are
//   strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module rectangle_table_hit_and_overlap (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [rthov_pkg::OPC_W-1:0]               opcode,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  rect_left,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  rect_top,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  rect_right,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  rect_bottom,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  point_x,
	input  logic signed [rthov_pkg::COORD_WIDTH-1:0]  point_y,
	output logic                                      strobe,
	output logic [rthov_pkg::KIND_W-1:0]              kind,
	output logic                                      status,
	output logic                                      found,
	output logic [rthov_pkg::INDEX_FIELD_W-1:0]       entry_index,
	output logic signed [rthov_pkg::COORD_WIDTH-1:0]  out_left,
	output logic signed [rthov_pkg::COORD_WIDTH-1:0]  out_top,
	output logic signed [rthov_pkg::COORD_WIDTH-1:0]  out_right,
	output logic signed [rthov_pkg::COORD_WIDTH-1:0]  out_bottom,
	output logic                                      last
);

	localparam int unsigned D = rthov_pkg::DEPTH;

	// How it works.
	// Every table entry lives in its own cell; cell i holds entry i at rest.
	// Each cell also carries a probe register that moves around a ring.
	// A hit-test loads the query point into every probe and tests all cells
	// at once. A filter loads each cell's own entry as its probe and rotates
	// the probe ring one full turn, so that every entry meets every
	// other one; a cell marks itself as soon as any other valid entry
	// overlaps it. After that the home entries and their marks rotate DEPTH
	// hops toward cell 0, which presents the entries in table order to the
	// result logic; the full turn brings the table back where it was.

	rthov_pkg::state_t           state_q, state_nxt;
	rthov_pkg::cell_ctrl_t       ctrl;
	rthov_pkg::opcode_t          op_in;
	logic                        accept;
	logic                        is_hit_q;
	logic [rthov_pkg::CNT_W-1:0] count_q;
	logic [rthov_pkg::IDX_W-1:0] k_q;
	logic [rthov_pkg::IDX_W-1:0] e_q;
	logic                        k_end;
	logic                        e_end;
	logic                        entry_valid;

	logic                        found_q;
	logic [rthov_pkg::IDX_W-1:0] hit_idx_q;
	logic                        pend_q;
	logic [rthov_pkg::IDX_W-1:0] pend_idx_q;
	rthov_pkg::rect_t            pend_rect_q;
	logic [rthov_pkg::KEPT_W-1:0] kept_cnt_q;

	logic                        strobe_q;
	rthov_pkg::result_t          res_q;

	rthov_pkg::rect_t            wr_rect;
	rthov_pkg::rect_t            point_rect;
	rthov_pkg::rect_t            home  [D];
	rthov_pkg::rect_t            probe [D];
	logic [D-1:0]                flag;
	logic [D-1:0]                probe_valid;
	logic [D-1:0]                home_valid;
	logic [D-1:0]                we;

	assign op_in  = rthov_pkg::opcode_t'(opcode);
	assign busy   = (state_q != rthov_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign k_end  = (k_q == rthov_pkg::IDX_W'(D - 1));
	assign e_end  = (e_q == rthov_pkg::IDX_W'(D - 1));

	// Cell 0 holds entry e_q during the scan; only entries below the count exist.
	assign entry_valid = ({{(rthov_pkg::CNT_W - rthov_pkg::IDX_W){1'b0}}, e_q} < count_q);

	assign wr_rect    = '{l: rect_left, t: rect_top, r: rect_right, b: rect_bottom};
	// A point is a rectangle of zero extent, so containment is plain overlap.
	assign point_rect = '{l: point_x, t: point_y, r: point_x, b: point_y};

	// The chain of cells. Each cell takes its neighbor's home, flag and probe.
	for (genvar c = 0; c < D; c++) begin : g_cell
		localparam int unsigned NXT = (c + 1) % D;

		assign home_valid[c] = (rthov_pkg::CNT_W'(c) < count_q);
		assign we[c]         = accept && (op_in == rthov_pkg::OP_APPEND) &&
		                       (count_q == rthov_pkg::CNT_W'(c));

		rthov_cell u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.ctrl            (ctrl),
			.we              (we[c]),
			.wr_rect         (wr_rect),
			.point_rect      (point_rect),
			.home_valid      (home_valid[c]),
			.nbr_home        (home[NXT]),
			.nbr_flag        (flag[NXT]),
			.nbr_probe       (probe[NXT]),
			.nbr_probe_valid (probe_valid[NXT]),
			.home            (home[c]),
			.flag            (flag[c]),
			.probe           (probe[c]),
			.probe_valid     (probe_valid[c])
		);
	end

	// Next-state logic of the controller.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rthov_pkg::ST_IDLE: begin
				if (accept && ((op_in == rthov_pkg::OP_HIT) ||
				               (op_in == rthov_pkg::OP_FILTER))) begin
					state_nxt = rthov_pkg::ST_CMP;
				end
			end
			rthov_pkg::ST_CMP: begin
				// A hit-test compares once; a filter walks the ring.
				if (is_hit_q || k_end) begin
					state_nxt = rthov_pkg::ST_SCAN;
				end
			end
			rthov_pkg::ST_SCAN: begin
				if (e_end) begin
					state_nxt = rthov_pkg::ST_FINISH;
				end
			end
			rthov_pkg::ST_FINISH: begin
				state_nxt = rthov_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = rthov_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic of the controller: the control bundle for the cells.
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			rthov_pkg::ST_IDLE: begin
				ctrl.load       = accept && ((op_in == rthov_pkg::OP_HIT) ||
				                             (op_in == rthov_pkg::OP_FILTER));
				ctrl.point_mode = (op_in == rthov_pkg::OP_HIT);
			end
			rthov_pkg::ST_CMP: begin
				// On the first filter hop each probe still holds its own entry,
				// so that hop only moves the ring.
				ctrl.cmp_en      = is_hit_q || (k_q != '0);
				ctrl.shift_probe = !is_hit_q;
			end
			rthov_pkg::ST_SCAN: begin
				ctrl.rotate_home = 1'b1;
			end
			rthov_pkg::ST_FINISH: begin
				ctrl = '0;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rthov_pkg::ST_IDLE;
			count_q    <= '0;
			strobe_q   <= 1'b0;
			pend_q     <= 1'b0;
			found_q    <= 1'b0;
			kept_cnt_q <= '0;
			is_hit_q   <= 1'b0;
			k_q        <= '0;
			e_q        <= '0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= 1'b0;
			unique case (state_q)
				rthov_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (op_in)
							rthov_pkg::OP_CLEAR: begin
								count_q  <= '0;
								strobe_q <= 1'b1;
							end
							rthov_pkg::OP_APPEND: begin
								if (count_q != rthov_pkg::CNT_W'(D)) begin
									count_q <= count_q + rthov_pkg::CNT_W'(1);
								end
								strobe_q <= 1'b1;
							end
							rthov_pkg::OP_HIT, rthov_pkg::OP_FILTER: begin
								is_hit_q   <= (op_in == rthov_pkg::OP_HIT);
								k_q        <= '0;
								e_q        <= '0;
								found_q    <= 1'b0;
								pend_q     <= 1'b0;
								kept_cnt_q <= '0;
							end
							default: begin
								strobe_q <= 1'b0;
							end
						endcase
					end
				end
				rthov_pkg::ST_CMP: begin
					k_q <= k_q + rthov_pkg::IDX_W'(1);
				end
				rthov_pkg::ST_SCAN: begin
					e_q <= e_q + rthov_pkg::IDX_W'(1);
					if (is_hit_q) begin
						// Only the lowest-indexed containing entry counts.
						if (entry_valid && flag[0] && !found_q) begin
							found_q <= 1'b1;
						end
					end else if (entry_valid && !flag[0] &&
					             (kept_cnt_q < rthov_pkg::KEPT_W'(rthov_pkg::MAX_RESULTS))) begin
						// A survivor is held back one step so that the final
						// one can carry the last marker.
						pend_q     <= 1'b1;
						kept_cnt_q <= kept_cnt_q + rthov_pkg::KEPT_W'(1);
						if (pend_q) begin
							strobe_q <= 1'b1;
						end
					end
				end
				rthov_pkg::ST_FINISH: begin
					strobe_q <= 1'b1;
				end
				default: begin
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	// Result payload and the side registers of the scan; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rthov_pkg::ST_IDLE: begin
				res_q <= '{kind: rthov_pkg::KIND_ACK,
				           status: (op_in == rthov_pkg::OP_APPEND) &&
				                   (count_q == rthov_pkg::CNT_W'(D)),
				           found: 1'b0, idx: '0, rect: '0, last: 1'b1};
			end
			rthov_pkg::ST_CMP: begin
				res_q <= res_q;
			end
			rthov_pkg::ST_SCAN: begin
				if (is_hit_q) begin
					if (entry_valid && flag[0] && !found_q) begin
						hit_idx_q <= e_q;
					end
				end else if (entry_valid && !flag[0] &&
				             (kept_cnt_q < rthov_pkg::KEPT_W'(rthov_pkg::MAX_RESULTS))) begin
					pend_idx_q  <= e_q;
					pend_rect_q <= home[0];
					res_q <= '{kind: rthov_pkg::KIND_KEPT, status: 1'b0, found: 1'b0,
					           idx: rthov_pkg::idx_to_field(pend_idx_q),
					           rect: pend_rect_q, last: 1'b0};
				end
			end
			rthov_pkg::ST_FINISH: begin
				if (is_hit_q) begin
					res_q <= '{kind: rthov_pkg::KIND_HIT, status: 1'b0, found: found_q,
					           idx: found_q ? rthov_pkg::idx_to_field(hit_idx_q) : '0,
					           rect: '0, last: 1'b1};
				end else if (pend_q) begin
					res_q <= '{kind: rthov_pkg::KIND_KEPT, status: 1'b0, found: 1'b0,
					           idx: rthov_pkg::idx_to_field(pend_idx_q),
					           rect: pend_rect_q, last: 1'b1};
				end else begin
					res_q <= '{kind: rthov_pkg::KIND_NONE, status: 1'b0, found: 1'b0,
					           idx: '0, rect: '0, last: 1'b1};
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign strobe      = strobe_q;
	assign kind        = res_q.kind;
	assign status      = res_q.status;
	assign found       = res_q.found;
	assign entry_index = res_q.idx;
	assign out_left    = res_q.rect.l;
	assign out_top     = res_q.rect.t;
	assign out_right   = res_q.rect.r;
	assign out_bottom  = res_q.rect.b;
	assign last        = res_q.last;

	// The table never holds more entries than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rthov_pkg::CNT_W'(D))
		else $error("entry count exceeds table depth");

	// An append into a full table answers next cycle with the full status.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_in == rthov_pkg::OP_APPEND) && (count_q == rthov_pkg::CNT_W'(D)))
		|=> (strobe && status && (count_q == rthov_pkg::CNT_W'(D))))
		else $error("append into full table not reported or table changed");

	// A scan always ends with its final transaction as busy drops.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("busy dropped without a final transaction");

	// Acknowledges and empty-filter markers are single transactions.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && ((kind == rthov_pkg::KIND_ACK) || (kind == rthov_pkg::KIND_NONE)))
		|-> (last && (entry_index == '0) && !found))
		else $error("malformed acknowledge or empty marker");

endmodule
